// File: rtl/svtq_pkg.sv
// shared constants and types for the sorted virtual timer queue
package svtq_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int TIME_W = 64;

    typedef enum logic [2:0] {
        ACT_ADD     = 3'd0,
        ACT_ADD_PER = 3'd1,
        ACT_MOD     = 3'd2,
        ACT_MOD_PER = 3'd3,
        ACT_DEL     = 3'd4,
        ACT_FWD     = 3'd5,
        ACT_EXPIRE  = 3'd6,
        ACT_NONE    = 3'd7
    } action_t;

endpackage

// File: rtl/sorted_virtual_timer_queue_core.sv
// top level of the sorted virtual timer queue: sequencer around three rams
//
//  channel | dir | tdata (low bit up)                    | tuser | tlast
//  s_      | in  | action[2:0] slot[6:3] amount[70:7]    | -     | -
//  m_      | out | flag[0] fired_valid[1] fired_slot[5:2] | -     | last result of item
//
// one item at a time; add/mod/del walk the order ram entry by entry
// (remove, then sorted insert for add/mod), forward needs no walk,
// expire walks the queue entry by entry, then hands over each fired timer
// plus a sorted re-insert for periodic ones; the chained order then time ram read sets the pace
// reset clears pending flags, count, accumulator and earliest; rams are not cleared
// a stalled result sits in the output register; the sequencer waits only when it
// has a further result to hand over
module sorted_virtual_timer_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // action, slot, amount
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // flag, fired_valid, fired_slot
    output logic        m_tlast
);
    import svtq_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_MOD_CHK, ST_RM_RD, ST_RM_CHK, ST_SET,
        ST_INS_RD, ST_INS_ENT, ST_INS_CMP, ST_EX_RD, ST_EX_ENT, ST_EX_CMP,
        ST_EX_END, ST_EX_OUT, ST_EX_PER, ST_EX_NEXT, ST_RESULT
    } state_t;

    state_t              state_reg;
    action_t             op_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [TIME_W-1:0]   amt_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [TIME_W-1:0]   acc_reg;
    logic [TIME_W-1:0]   earl_reg;
    logic [SLOTS-1:0]    pending_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    nk_reg;
    logic [CNT_W-1:0]    nf_reg;
    logic [CNT_W-1:0]    fi_reg;
    logic                found_reg;
    logic                flag_reg;
    logic [TIME_W-1:0]   val_reg;
    logic [SLOT_W-1:0]   ent_reg;
    logic [SLOT_W-1:0]   ins_reg;
    logic [SLOT_W-1:0]   fired_reg [SLOTS];
    logic                out_valid_reg;
    logic [7:0]          out_data_reg;
    logic                out_last_reg;

    // ram ports
    logic                rem_we, per_we, ord_we;
    logic [SLOT_W-1:0]   rem_waddr, rem_raddr, per_waddr, per_raddr, ord_waddr, ord_raddr;
    logic [TIME_W-1:0]   rem_wdata, rem_rdata, per_wdata, per_rdata;
    logic [SLOT_W-1:0]   ord_wdata, ord_rdata;

    logic                s_accept, out_free, slot_ok, periodic;
    logic [TIME_W-1:0]   set_val, fwd_acc, ex_rebased;
    logic [CNT_W-1:0]    idx_dec;
    logic [SLOT_W-1:0]   fired_cur;

    assign s_accept   = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign out_free   = !out_valid_reg || m_tready;
    assign slot_ok    = ({1'b0, slot_reg} < CNT_W'(SLOTS));
    assign periodic   = (op_reg == ACT_ADD_PER) || (op_reg == ACT_MOD_PER);
    assign set_val    = (count_reg == '0) ? amt_reg : amt_reg + acc_reg;
    assign fwd_acc    = acc_reg + amt_reg;
    assign ex_rebased = rem_rdata - acc_reg;
    assign idx_dec    = idx_reg - CNT_W'(1);
    assign fired_cur  = fired_reg[fi_reg[SLOT_W-1:0]];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    svtq_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_rem (
        .aclk(aclk), .we(rem_we), .waddr(rem_waddr), .wdata(rem_wdata),
        .raddr(rem_raddr), .rdata(rem_rdata)
    );
    svtq_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_per (
        .aclk(aclk), .we(per_we), .waddr(per_waddr), .wdata(per_wdata),
        .raddr(per_raddr), .rdata(per_rdata)
    );
    svtq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_ord (
        .aclk(aclk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata)
    );

    // ram address and write steering per sequencer state
    always_comb begin
        rem_we = 1'b0; rem_waddr = '0; rem_wdata = '0; rem_raddr = '0;
        per_we = 1'b0; per_waddr = '0; per_wdata = '0; per_raddr = '0;
        ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_raddr = '0;
        unique case (state_reg)
            ST_DISPATCH: rem_raddr = slot_reg;
            ST_RM_RD:    ord_raddr = idx_reg[SLOT_W-1:0];
            ST_RM_CHK: begin
                // entries behind the removed one move down by one
                ord_we    = found_reg;
                ord_waddr = idx_dec[SLOT_W-1:0];
                ord_wdata = ord_rdata;
            end
            ST_SET: begin
                rem_we    = 1'b1;
                rem_waddr = slot_reg;
                rem_wdata = set_val;
                per_we    = 1'b1;
                per_waddr = slot_reg;
                per_wdata = periodic ? amt_reg : '0;
                ord_we    = (count_reg == '0);
                ord_waddr = '0;
                ord_wdata = slot_reg;
            end
            ST_INS_RD: begin
                ord_raddr = idx_dec[SLOT_W-1:0];
                ord_we    = (idx_reg == '0);
                ord_waddr = '0;
                ord_wdata = ins_reg;
            end
            ST_INS_ENT:  rem_raddr = ord_rdata;
            ST_INS_CMP: begin
                // later entries shift up; stop after the last one not greater
                ord_we    = 1'b1;
                ord_waddr = idx_reg[SLOT_W-1:0];
                ord_wdata = (rem_rdata > val_reg) ? ent_reg : ins_reg;
            end
            ST_EX_RD:    ord_raddr = idx_reg[SLOT_W-1:0];
            ST_EX_ENT:   rem_raddr = ord_rdata;
            ST_EX_CMP: begin
                rem_we    = !(rem_rdata < acc_reg);
                rem_waddr = ent_reg;
                rem_wdata = ex_rebased;
                ord_we    = !(rem_rdata < acc_reg);
                ord_waddr = nk_reg[SLOT_W-1:0];
                ord_wdata = ent_reg;
            end
            ST_EX_OUT:   per_raddr = fired_cur;
            ST_EX_PER: begin
                rem_we    = (per_rdata != '0);
                rem_waddr = fired_cur;
                rem_wdata = per_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            acc_reg       <= '0;
            earl_reg      <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        op_reg    <= action_t'(s_tdata[2:0]);
                        slot_reg  <= s_tdata[6:3];
                        amt_reg   <= s_tdata[70:7];
                        flag_reg  <= 1'b0;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    unique case (op_reg)
                        ACT_ADD, ACT_ADD_PER: begin
                            if (!slot_ok) state_reg <= ST_RESULT;
                            else if (pending_reg[slot_reg]) state_reg <= ST_RM_RD;
                            else state_reg <= ST_SET;
                        end
                        ACT_MOD, ACT_MOD_PER: begin
                            state_reg <= slot_ok ? ST_MOD_CHK : ST_RESULT;
                        end
                        ACT_DEL: begin
                            if (slot_ok && pending_reg[slot_reg]) begin
                                flag_reg  <= 1'b1;
                                state_reg <= ST_RM_RD;
                            end else begin
                                state_reg <= ST_RESULT;
                            end
                        end
                        ACT_FWD: begin
                            if (count_reg != '0) begin
                                acc_reg  <= fwd_acc;
                                flag_reg <= (fwd_acc >= earl_reg);
                            end
                            state_reg <= ST_RESULT;
                        end
                        ACT_EXPIRE: begin
                            nk_reg    <= '0;
                            nf_reg    <= '0;
                            state_reg <= ST_EX_RD;
                        end
                        ACT_NONE: state_reg <= ST_RESULT;
                    endcase
                end
                ST_MOD_CHK: begin
                    flag_reg <= pending_reg[slot_reg];
                    if (pending_reg[slot_reg] && rem_rdata == amt_reg) begin
                        state_reg <= ST_RESULT;
                    end else if (pending_reg[slot_reg]) begin
                        state_reg <= ST_RM_RD;
                    end else begin
                        state_reg <= ST_SET;
                    end
                end
                ST_RM_RD: begin
                    if (idx_reg == count_reg) begin
                        if (found_reg) count_reg <= count_reg - CNT_W'(1);
                        pending_reg[slot_reg] <= 1'b0;
                        state_reg <= (op_reg == ACT_DEL) ? ST_RESULT : ST_SET;
                    end else begin
                        state_reg <= ST_RM_CHK;
                    end
                end
                ST_RM_CHK: begin
                    if (ord_rdata == slot_reg) found_reg <= 1'b1;
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= ST_RM_RD;
                end
                ST_SET: begin
                    if (count_reg == '0) begin
                        earl_reg              <= amt_reg;
                        acc_reg               <= '0;
                        count_reg             <= CNT_W'(1);
                        pending_reg[slot_reg] <= 1'b1;
                        state_reg             <= ST_RESULT;
                    end else begin
                        if ($signed(set_val) < $signed(earl_reg)) earl_reg <= set_val;
                        val_reg   <= set_val;
                        ins_reg   <= slot_reg;
                        idx_reg   <= count_reg;
                        state_reg <= ST_INS_RD;
                    end
                end
                ST_INS_RD: begin
                    if (idx_reg == '0) begin
                        count_reg            <= count_reg + CNT_W'(1);
                        pending_reg[ins_reg] <= 1'b1;
                        state_reg <= (op_reg == ACT_EXPIRE) ? ST_EX_NEXT : ST_RESULT;
                    end else begin
                        state_reg <= ST_INS_ENT;
                    end
                end
                ST_INS_ENT: begin
                    ent_reg   <= ord_rdata;
                    state_reg <= ST_INS_CMP;
                end
                ST_INS_CMP: begin
                    if (rem_rdata > val_reg) begin
                        idx_reg   <= idx_dec;
                        state_reg <= ST_INS_RD;
                    end else begin
                        count_reg            <= count_reg + CNT_W'(1);
                        pending_reg[ins_reg] <= 1'b1;
                        state_reg <= (op_reg == ACT_EXPIRE) ? ST_EX_NEXT : ST_RESULT;
                    end
                end
                ST_EX_RD: begin
                    state_reg <= (idx_reg == count_reg) ? ST_EX_END : ST_EX_ENT;
                end
                ST_EX_ENT: begin
                    ent_reg   <= ord_rdata;
                    state_reg <= ST_EX_CMP;
                end
                ST_EX_CMP: begin
                    if (rem_rdata < acc_reg) begin
                        fired_reg[nf_reg[SLOT_W-1:0]] <= ent_reg;
                        nf_reg               <= nf_reg + CNT_W'(1);
                        pending_reg[ent_reg] <= 1'b0;
                    end else begin
                        if (nk_reg == '0) earl_reg <= ex_rebased;
                        nk_reg <= nk_reg + CNT_W'(1);
                    end
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= ST_EX_RD;
                end
                ST_EX_END: begin
                    count_reg <= nk_reg;
                    acc_reg   <= '0;
                    fi_reg    <= '0;
                    state_reg <= (nf_reg == '0) ? ST_RESULT : ST_EX_OUT;
                end
                ST_EX_OUT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {2'b00, fired_cur, 1'b1, 1'b0};
                        out_last_reg  <= (fi_reg + CNT_W'(1) == nf_reg);
                        state_reg     <= ST_EX_PER;
                    end
                end
                ST_EX_PER: begin
                    if (per_rdata != '0) begin
                        // periodic re-arm against a cleared accumulator
                        val_reg   <= per_rdata;
                        ins_reg   <= fired_cur;
                        idx_reg   <= count_reg;
                        state_reg <= ST_INS_RD;
                    end else begin
                        state_reg <= ST_EX_NEXT;
                    end
                end
                ST_EX_NEXT: begin
                    fi_reg    <= fi_reg + CNT_W'(1);
                    state_reg <= (fi_reg + CNT_W'(1) == nf_reg) ? ST_IDLE : ST_EX_OUT;
                end
                ST_RESULT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {7'd0, flag_reg};
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // queue length matches the pending flags whenever the sequencer rests
    a_count_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (count_reg == CNT_W'($countones(pending_reg))))
        else $error("queue length differs from pending flags");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("new item taken while one is in work");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOTS))
        else $error("queue length beyond slot count");
`endif

endmodule

// File: rtl/svtq_ram.sv
// simple dual-port ram with registered read
module svtq_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
